[rtl/dmct_pkg.sv]
// Shared types, constants and digit helpers for the dual-mode countdown and temperature monitor.
`default_nettype none

package dmct_pkg;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 48;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [2:0] KIND_QUARTER    = 3'd0;
    localparam logic [2:0] KIND_SECOND     = 3'd1;
    localparam logic [2:0] KIND_START_STOP = 3'd2;
    localparam logic [2:0] KIND_MODE       = 3'd3;
    localparam logic [2:0] KIND_SAMPLE     = 3'd4;

    localparam logic [1:0] REG_SHORT_RELOAD = 2'd0;
    localparam logic [1:0] REG_LONG_RELOAD  = 2'd1;
    localparam logic [1:0] REG_QUARTERS     = 2'd2;
    localparam logic [1:0] REG_THRESHOLD    = 2'd3;

    localparam logic [6:0] SHORT_RELOAD_RST = 7'd10;
    localparam logic [6:0] LONG_RELOAD_RST  = 7'd60;
    localparam logic [3:0] QUARTERS_RST     = 4'd4;
    localparam logic [9:0] THRESHOLD_RST    = 10'd500;

    localparam logic [6:0] ADC_MUL   = 7'd125;
    localparam int         ADC_SHIFT = 7;

    typedef struct packed {
        logic [6:0] short_reload;
        logic [6:0] long_reload;
        logic [3:0] quarters;
        logic [9:0] threshold;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        logic [9:0] temp;
    } in_item_t;

    // Quotient by ten of a 7-bit value, exact over the whole range.
    function automatic logic [3:0] div10_7(input logic [6:0] x);
        logic [14:0] p;
        p = 15'(x) * 15'd205;
        return p[14:11];
    endfunction

    // Quotient by ten of a 10-bit value, exact over the whole range.
    function automatic logic [6:0] div10_10(input logic [9:0] x);
        logic [17:0] p;
        p = 18'(x) * 18'd205;
        return p[17:11];
    endfunction

    // Quotient by one hundred of a 10-bit value, exact over the whole range.
    function automatic logic [3:0] div100_10(input logic [9:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'd41;
        return p[15:12];
    endfunction

endpackage

`default_nettype wire

[rtl/dmct_regs.sv]
// APB register bank holding the reload values, prescale length and alarm threshold.
`default_nettype none

module dmct_regs import dmct_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_reload <= SHORT_RELOAD_RST;
            cfg_reg.long_reload  <= LONG_RELOAD_RST;
            cfg_reg.quarters     <= QUARTERS_RST;
            cfg_reg.threshold    <= THRESHOLD_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_SHORT_RELOAD: cfg_reg.short_reload <= pwdata[6:0];
                REG_LONG_RELOAD:  cfg_reg.long_reload  <= pwdata[6:0];
                REG_QUARTERS:     cfg_reg.quarters     <= pwdata[3:0];
                REG_THRESHOLD:    cfg_reg.threshold    <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_SHORT_RELOAD: prdata = APB_DATA_W'(cfg_reg.short_reload);
            REG_LONG_RELOAD:  prdata = APB_DATA_W'(cfg_reg.long_reload);
            REG_QUARTERS:     prdata = APB_DATA_W'(cfg_reg.quarters);
            REG_THRESHOLD:    prdata = APB_DATA_W'(cfg_reg.threshold);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/dmct_in_stage.sv]
// Input register that captures each transaction and converts the ADC reading to tenths of a degree.
`default_nettype none

module dmct_in_stage import dmct_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    input  wire logic [IN_TUSER_W-1:0] s_tuser,
    input  wire logic                  advance,
    output in_item_t                   in_item
);

    logic       valid_reg;
    logic [2:0] kind_reg;
    logic [9:0] temp_reg;
    logic [16:0] scaled;

    assign s_tready = !valid_reg || advance;
    assign scaled   = 17'(s_tdata[9:0]) * 17'(ADC_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg <= s_tuser[2:0];
            temp_reg <= scaled[ADC_SHIFT +: 10];
        end
    end

    assign in_item.valid = valid_reg;
    assign in_item.kind  = kind_reg;
    assign in_item.temp  = temp_reg;

endmodule

`default_nettype wire

[rtl/dmct_core.sv]
// Timer and temperature state, next-state logic and the result register with digit split.
`default_nettype none

module dmct_core import dmct_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cfg_t                   cfg,
    input  wire in_item_t               in_item,
    output logic                        advance,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata
);

    logic       run_reg, run_next;
    logic       mode_reg, mode_next;
    logic [6:0] short_reg, short_next;
    logic [6:0] long_reg, long_next;
    logic [3:0] presc_reg, presc_next;
    logic [9:0] temp_reg, temp_next;
    logic       alarm_reg, alarm_next;
    logic       out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic       consume;

    logic [6:0] cnt;
    logic [3:0] cnt_tens, cnt_units;
    logic [6:0] t_div10;
    logic [3:0] t_hund, t_tens, t_units;

    assign advance  = !out_valid_reg || m_tready;
    assign consume  = in_item.valid && advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        run_next   = run_reg;
        mode_next  = mode_reg;
        short_next = short_reg;
        long_next  = long_reg;
        presc_next = presc_reg;
        temp_next  = temp_reg;
        alarm_next = alarm_reg;
        case (in_item.kind)
            KIND_QUARTER: begin
                if (run_reg && !mode_reg) begin
                    if (presc_reg <= 4'd1) begin
                        presc_next = cfg.quarters;
                        if (short_reg <= 7'd1) begin
                            short_next = cfg.short_reload;
                            run_next   = 1'b0;
                        end else begin
                            short_next = short_reg - 7'd1;
                        end
                    end else begin
                        presc_next = presc_reg - 4'd1;
                    end
                end
            end
            KIND_SECOND: begin
                if (run_reg && mode_reg) begin
                    if (long_reg <= 7'd1) begin
                        long_next = cfg.long_reload;
                        run_next  = 1'b0;
                    end else begin
                        long_next = long_reg - 7'd1;
                    end
                end
            end
            KIND_START_STOP: begin
                run_next = !run_reg;
            end
            KIND_MODE: begin
                mode_next = !mode_reg;
                if (!mode_reg) begin
                    short_next = cfg.short_reload;
                end else begin
                    long_next = cfg.long_reload;
                end
            end
            KIND_SAMPLE: begin
                if (run_reg) begin
                    temp_next  = in_item.temp;
                    alarm_next = in_item.temp > cfg.threshold;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        cnt       = mode_next ? long_next : short_next;
        cnt_tens  = div10_7(cnt);
        cnt_units = 4'(cnt - 7'(cnt_tens) * 7'd10);
        t_div10   = div10_10(temp_next);
        t_hund    = div100_10(temp_next);
        t_tens    = 4'(t_div10 - 7'(t_hund) * 7'd10);
        t_units   = 4'(temp_next - 10'(t_div10) * 10'd10);
        out_data_next = {7'd0, alarm_next, t_units, t_tens, t_hund, temp_next,
                         mode_next, run_next, (cnt < 7'd10), cnt_units, cnt_tens, cnt};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg       <= 1'b0;
            mode_reg      <= 1'b0;
            short_reg     <= SHORT_RELOAD_RST;
            long_reg      <= LONG_RELOAD_RST;
            presc_reg     <= QUARTERS_RST;
            temp_reg      <= '0;
            alarm_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (consume) begin
                run_reg   <= run_next;
                mode_reg  <= mode_next;
                short_reg <= short_next;
                long_reg  <= long_next;
                presc_reg <= presc_next;
                temp_reg  <= temp_next;
                alarm_reg <= alarm_next;
            end
            if (advance) begin
                out_valid_reg <= in_item.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (consume) begin
            out_data_reg <= out_data_next;
        end
    end

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        consume |=> out_valid_reg)
        else $error("Accepted transaction did not produce a result.");

    a_run_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $fell(run_reg) |->
            $past(consume) && ($past(in_item.kind) == KIND_QUARTER ||
                               $past(in_item.kind) == KIND_SECOND ||
                               $past(in_item.kind) == KIND_START_STOP))
        else $error("Timer stopped without a tick or a start/stop press.");

    a_mode_change: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(mode_reg) |->
            $past(consume && in_item.kind == KIND_MODE))
        else $error("Mode changed without a mode toggle.");

    a_temp_change: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(temp_reg) |->
            $past(consume && in_item.kind == KIND_SAMPLE && run_reg))
        else $error("Temperature changed without a sample while running.");

endmodule

`default_nettype wire

[rtl/dual_mode_countdown_temp_monitor_top.sv]
// Top level of the dual-mode countdown timer with temperature monitor.
// Each input transaction (quarter tick, second tick, start/stop press, mode toggle or ADC
// sample, selected by s_tuser) yields exactly one result transaction that shows the timer
// and temperature state after that event. One transaction is taken every clock cycle while
// m_tready does not hold the result; each result passes through the input register (which
// also scales the ADC reading by 125/128) and then the result register. Registers on the
// APB port are at byte addresses 0x0 short reload, 0x4 long reload, 0x8 quarter ticks per
// second and 0xC alarm threshold in tenths of a degree; new reload values take effect at
// the next reload. Write them only while no transaction is in flight.
`default_nettype none

module dual_mode_countdown_temp_monitor_top import dmct_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [9:0] adc_sample, upper bits ignored.
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // [2:0] kind.
    input  wire logic [IN_TUSER_W-1:0]  s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [6:0] remaining_seconds, [10:7] count_tens, [14:11] count_units, [15] tens_blank,
    // [16] running, [17] long_mode, [27:18] temp_tenths, [31:28] temp_hundreds,
    // [35:32] temp_tens, [39:36] temp_units, [40] over_temp, [47:41] zero.
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic      [APB_DATA_W-1:0]  prdata,
    output logic                        pready
);

    cfg_t     cfg;
    in_item_t in_item;
    logic     advance;

    dmct_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dmct_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .advance  (advance),
        .in_item  (in_item)
    );

    dmct_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_item  (in_item),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
